// ----- rtl/tfr_pkg.sv -----
package tfr_pkg;

    // frame and acknowledge constants
    localparam logic [7:0] HDR0     = 8'hAA;
    localparam logic [7:0] HDR1     = 8'hAF;
    localparam logic [7:0] ACK_LEAD = 8'hAA;
    localparam logic [7:0] ACK_FUNC = 8'hEF;
    localparam logic [7:0] ACK_LEN  = 8'h02;

    // acknowledge frame byte slots
    localparam logic [2:0] ACK_IDX_LEAD0 = 3'd0;
    localparam logic [2:0] ACK_IDX_LEAD1 = 3'd1;
    localparam logic [2:0] ACK_IDX_FUNC  = 3'd2;
    localparam logic [2:0] ACK_IDX_LEN   = 3'd3;
    localparam logic [2:0] ACK_IDX_CODE  = 3'd4;
    localparam logic [2:0] ACK_IDX_SUM   = 3'd5;
    localparam logic [2:0] ACK_IDX_CHK   = 3'd6;

    // queue depth, also the number of payload banks
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // one validated frame waiting to be sent
    typedef struct packed {
        logic [7:0] func;
        logic [7:0] sum;
        logic [7:0] len;
        logic       bank;
    } job_t;

    // back end status seen by the top level
    typedef struct packed {
        logic busy;
        logic bank;
    } back_status_t;

    typedef enum logic [2:0] {
        FR_HUNT,
        FR_HDR1,
        FR_FUNC,
        FR_LEN,
        FR_PAY,
        FR_CHECK
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACK,
        BK_PAY
    } back_state_t;

    // byte of the acknowledge frame at a slot
    function automatic logic [7:0] ack_byte(input logic [2:0] idx,
                                            input logic [7:0] func,
                                            input logic [7:0] sum);
        logic [7:0] chk;
        logic [7:0] res;
        chk = ACK_LEAD + ACK_LEAD + ACK_FUNC + ACK_LEN + func + sum;
        case (idx)
            ACK_IDX_LEAD0: res = ACK_LEAD;
            ACK_IDX_LEAD1: res = ACK_LEAD;
            ACK_IDX_FUNC:  res = ACK_FUNC;
            ACK_IDX_LEN:   res = ACK_LEN;
            ACK_IDX_CODE:  res = func;
            ACK_IDX_SUM:   res = sum;
            ACK_IDX_CHK:   res = chk;
            default:       res = ACK_LEAD;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/tfr_ram.sv -----
module tfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ----- rtl/tfr_queue.sv -----
module tfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tfr_pkg::job_t push_job,
    input  logic          pop,
    output tfr_pkg::job_t head,
    output logic          not_empty,
    output logic [1:0]    count
);

    tfr_pkg::job_t entry_reg [2];
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    // pointer and fill count update
    always_comb
    begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;

    // no push into a full queue, no pop from an empty one
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != tfr_pkg::QUEUE_DEPTH))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("pop from empty queue");

endmodule

// ----- rtl/tfr_front.sv -----
module tfr_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [7:0]                              in_byte,
    input  logic                                    hold,
    output logic                                    in_stall,
    output logic                                    push,
    output tfr_pkg::job_t                           push_job,
    output logic                                    wr_en,
    output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] wr_addr,
    output logic [7:0]                              wr_data
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    tfr_pkg::front_state_t state_reg;
    tfr_pkg::front_state_t state_next;
    logic [7:0] func_reg;
    logic [7:0] func_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic       bank_reg;
    logic       bank_next;
    logic       accept;
    logic [7:0] cnt_inc;

    assign cnt_inc = cnt_reg + 8'd1;

    // handshake, payload write and job push
    always_comb
    begin
        in_stall = hold && ((state_reg == tfr_pkg::FR_PAY) || (state_reg == tfr_pkg::FR_CHECK));
        accept   = in_valid && !in_stall;
        wr_en    = accept && (state_reg == tfr_pkg::FR_PAY);
        push     = accept && (state_reg == tfr_pkg::FR_CHECK) && (in_byte == sum_reg);
    end

    assign wr_addr       = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign wr_data       = in_byte;
    assign push_job.func = func_reg;
    assign push_job.sum  = sum_reg;
    assign push_job.len  = len_reg;
    assign push_job.bank = bank_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            case (state_reg)
                tfr_pkg::FR_HUNT:
                begin
                    if (in_byte == tfr_pkg::HDR0)
                    begin
                        state_next = tfr_pkg::FR_HDR1;
                    end
                end
                tfr_pkg::FR_HDR1:
                begin
                    state_next = (in_byte == tfr_pkg::HDR1) ? tfr_pkg::FR_FUNC
                                                            : tfr_pkg::FR_HUNT;
                end
                tfr_pkg::FR_FUNC:
                begin
                    state_next = tfr_pkg::FR_LEN;
                end
                tfr_pkg::FR_LEN:
                begin
                    if (in_byte > MAX_LEN)
                    begin
                        state_next = tfr_pkg::FR_HUNT;
                    end
                    else if (in_byte == 8'd0)
                    begin
                        state_next = tfr_pkg::FR_CHECK;
                    end
                    else
                    begin
                        state_next = tfr_pkg::FR_PAY;
                    end
                end
                tfr_pkg::FR_PAY:
                begin
                    if (cnt_inc == len_reg)
                    begin
                        state_next = tfr_pkg::FR_CHECK;
                    end
                end
                tfr_pkg::FR_CHECK:
                begin
                    state_next = tfr_pkg::FR_HUNT;
                end
                default:
                begin
                    state_next = tfr_pkg::FR_HUNT;
                end
            endcase
        end
    end

    // frame fields, running sum and payload count
    always_comb
    begin
        func_next = func_reg;
        len_next  = len_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        bank_next = push ? ~bank_reg : bank_reg;
        if (accept)
        begin
            case (state_reg)
                tfr_pkg::FR_HUNT:
                begin
                    sum_next = in_byte;
                end
                tfr_pkg::FR_HDR1:
                begin
                    sum_next = sum_reg + in_byte;
                end
                tfr_pkg::FR_FUNC:
                begin
                    func_next = in_byte;
                    sum_next  = sum_reg + in_byte;
                end
                tfr_pkg::FR_LEN:
                begin
                    if (in_byte <= MAX_LEN)
                    begin
                        len_next = in_byte;
                        sum_next = sum_reg + in_byte;
                        cnt_next = 8'd0;
                    end
                end
                tfr_pkg::FR_PAY:
                begin
                    sum_next = sum_reg + in_byte;
                    cnt_next = cnt_inc;
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfr_pkg::FR_HUNT;
            func_reg  <= 8'd0;
            len_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            bank_reg  <= bank_next;
        end
    end

    // payload writes stay inside the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < len_reg) && (len_reg <= MAX_LEN))
        else $error("payload write beyond frame length");

endmodule

// ----- rtl/tfr_back.sv -----
module tfr_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  tfr_pkg::job_t                           q_head,
    output logic                                    pop,
    output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] rd_addr,
    input  logic [7:0]                              rd_data,
    output tfr_pkg::back_status_t                   status,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    kind,
    output logic [7:0]                              func_code,
    output logic [7:0]                              data_byte,
    output logic                                    last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    tfr_pkg::back_state_t state_reg;
    tfr_pkg::back_state_t state_next;
    tfr_pkg::job_t        job_reg;
    tfr_pkg::job_t        job_next;
    logic [2:0]           ack_idx_reg;
    logic [2:0]           ack_idx_next;
    logic [7:0]           idx_reg;
    logic [7:0]           idx_next;
    logic [7:0]           idx_inc;
    logic                 load;
    logic                 emit;
    logic                 item_kind;
    logic [7:0]           item_data;
    logic                 item_last;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 kind_reg;
    logic [7:0]           func_reg;
    logic [7:0]           data_reg;
    logic                 last_reg;

    assign idx_inc = idx_reg + 8'd1;

    // item generation and queue pop
    always_comb
    begin
        load      = !out_valid_reg || !out_stall;
        emit      = load && (state_reg != tfr_pkg::BK_IDLE);
        pop       = (state_reg == tfr_pkg::BK_IDLE) && q_valid;
        item_kind = 1'b0;
        item_data = tfr_pkg::ack_byte(ack_idx_reg, job_reg.func, job_reg.sum);
        item_last = 1'b0;
        case (state_reg)
            tfr_pkg::BK_ACK:
            begin
                item_last = (ack_idx_reg == tfr_pkg::ACK_IDX_CHK) && (job_reg.len == 8'd0);
            end
            tfr_pkg::BK_PAY:
            begin
                item_kind = 1'b1;
                item_data = rd_data;
                item_last = (idx_inc == job_reg.len);
            end
            default:
            begin
                item_kind = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfr_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = tfr_pkg::BK_ACK;
                end
            end
            tfr_pkg::BK_ACK:
            begin
                if (emit && (ack_idx_reg == tfr_pkg::ACK_IDX_CHK))
                begin
                    state_next = (job_reg.len == 8'd0) ? tfr_pkg::BK_IDLE
                                                       : tfr_pkg::BK_PAY;
                end
            end
            tfr_pkg::BK_PAY:
            begin
                if (emit && item_last)
                begin
                    state_next = tfr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tfr_pkg::BK_IDLE;
            end
        endcase
    end

    // job, counters and read prefetch of the next payload byte
    always_comb
    begin
        job_next     = pop ? q_head : job_reg;
        ack_idx_next = ack_idx_reg;
        idx_next     = idx_reg;
        if (pop)
        begin
            ack_idx_next = 3'd0;
            idx_next     = 8'd0;
        end
        else if (emit && (state_reg == tfr_pkg::BK_ACK))
        begin
            ack_idx_next = ack_idx_reg + 3'd1;
        end
        else if (emit && (state_reg == tfr_pkg::BK_PAY))
        begin
            idx_next = idx_inc;
        end
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    assign rd_addr = {job_next.bank, idx_next[IDX_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfr_pkg::BK_IDLE;
            ack_idx_reg   <= 3'd0;
            idx_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ack_idx_reg   <= ack_idx_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job and output payload registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            kind_reg <= item_kind;
            func_reg <= job_reg.func;
            data_reg <= item_data;
            last_reg <= item_last;
        end
    end

    assign status.busy = (state_reg != tfr_pkg::BK_IDLE);
    assign status.bank = job_reg.bank;
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign func_code   = func_reg;
    assign data_byte   = data_reg;
    assign last        = last_reg;

    // payload phase only for frames that carry payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfr_pkg::BK_PAY) |-> (job_reg.len != 8'd0))
        else $error("payload phase with empty frame");

endmodule

// ----- rtl/telemetry_frame_receiver_with_ack.sv -----
// Receiver for framed telemetry bytes: hunts for the header AA AF, then takes a function
// code, a length (at most MAX_PAYLOAD), the payload and a modulo-256 checksum over all bytes
// before it. A frame whose checksum matches yields the acknowledge frame
// AA AA EF 02 func sum chk (kind 0) followed by its payload (kind 1), tagged with the
// function code, with last set on the final item of the frame; any other frame is dropped
// silently. An input byte is taken while in_valid is high and in_stall is low. A matching
// checksum byte yields 7 + length output items, one per cycle while out_stall is low, sent
// by a separate sequencer from a two-entry frame queue and a payload memory of two banks, so
// the next frame is parsed while the previous one drains. Payload and checksum bytes are held
// off (in_stall) only while both payload banks hold frames, queued or being sent. The payload
// memory needs no clearing after reset.
module telemetry_frame_receiver_with_ack #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] func_code,
    output logic [7:0] data_byte,
    output logic       last
);

    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic                  hold;
    logic                  push;
    tfr_pkg::job_t         push_job;
    logic                  pop;
    tfr_pkg::job_t         q_head;
    logic                  q_valid;
    logic [1:0]            q_count;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [7:0]            wr_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic [7:0]            rd_data;
    tfr_pkg::back_status_t status;

    // both payload banks in use: frames queued plus the one being sent
    assign hold = (q_count + {1'b0, status.busy}) >= tfr_pkg::QUEUE_DEPTH;

    tfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (rx_byte),
        .hold     (hold),
        .in_stall (in_stall),
        .push     (push),
        .push_job (push_job),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    tfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (q_head),
        .not_empty (q_valid),
        .count     (q_count)
    );

    tfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .func_code (func_code),
        .data_byte (data_byte),
        .last      (last)
    );

    // the parser never writes the bank that is being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && status.busy) |-> (wr_addr[ADDR_W-1] != status.bank))
        else $error("payload write into bank being sent");

    // never more frames in flight than payload banks
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !hold)
        else $error("frame accepted with both banks in use");

endmodule

// ----- dv/tb_telemetry_frame_receiver_with_ack.sv -----
module tb_telemetry_frame_receiver_with_ack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAYLOAD  = 32;
    localparam int PAY_IDX_W    = $clog2(MAX_PAYLOAD);
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_ITEMS   = 440;
    localparam int DIR_ROWS     = 25;

    // byte positions within a frame
    localparam logic [5:0] POS_HUNT = 6'd0;
    localparam logic [5:0] POS_HDR1 = 6'd1;
    localparam logic [5:0] POS_FUNC = 6'd2;
    localparam logic [5:0] POS_LEN  = 6'd3;
    localparam logic [5:0] POS_PAY  = 6'd4;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_PAY = 1'b1;

    // acknowledge of the empty frame with function code 00
    localparam logic [55:0] ZERO_LEN_ACK_BYTES = 56'hAA_AA_EF_02_00_59_9E;

    typedef struct packed {
        logic       kind;
        logic [7:0] func;
        logic [7:0] data;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_OUT,
        ZERO_LEN_ACK
    } row_check_t;

    typedef struct packed {
        logic [7:0] b;
        row_check_t chk;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] func_code;
    logic [7:0] data_byte;
    logic       last;

    // deframer state as predicted
    logic [5:0] rx_pos = POS_HUNT;
    logic [7:0] rx_func = 8'h00;
    logic [7:0] rx_len = 8'h00;
    logic [7:0] rx_sum = 8'h00;
    logic [7:0] pay_mem [MAX_PAYLOAD];

    out_item_t step_out [$];
    out_item_t pending_out [$];
    dir_row_t  dir_rows [DIR_ROWS];

    bit calm = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int live_items = 0;
    int acked_frames = 0;
    int checked_items = 0;
    int payload_items = 0;

    telemetry_frame_receiver_with_ack #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .func_code(func_code),
        .data_byte(data_byte),
        .last(last)
    );

    always #4 clk = ~clk;

    // next state and output items for one received byte
    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] ack [7];
        logic [7:0] chk;
        int total;
        int n;
        step_out.delete();
        if (rx_pos == POS_HUNT)
        begin
            if (b == tfr_pkg::HDR0)
            begin
                rx_sum = b;
                rx_pos = POS_HDR1;
            end
        end
        else if (rx_pos == POS_HDR1)
        begin
            // a second AA does not restart the header
            if (b == tfr_pkg::HDR1)
            begin
                rx_sum += b;
                rx_pos = POS_FUNC;
            end
            else
                rx_pos = POS_HUNT;
        end
        else if (rx_pos == POS_FUNC)
        begin
            rx_func = b;
            rx_sum += b;
            rx_pos = POS_LEN;
        end
        else if (rx_pos == POS_LEN)
        begin
            if (int'(b) > MAX_PAYLOAD)
                rx_pos = POS_HUNT;
            else
            begin
                rx_len = b;
                rx_sum += b;
                rx_pos = POS_PAY;
            end
        end
        else if (int'(rx_pos) < int'(POS_PAY) + int'(rx_len))
        begin
            pay_mem[PAY_IDX_W'(rx_pos - POS_PAY)] = b;
            rx_sum += b;
            rx_pos++;
        end
        else
        begin
            // checksum byte: acknowledge then payload on a match
            if (b == rx_sum)
            begin
                ack[0] = tfr_pkg::ACK_LEAD;
                ack[1] = tfr_pkg::ACK_LEAD;
                ack[2] = tfr_pkg::ACK_FUNC;
                ack[3] = tfr_pkg::ACK_LEN;
                ack[4] = rx_func;
                ack[5] = rx_sum;
                chk = 8'h00;
                for (int i = 0; i < 6; i++)
                    chk += ack[i];
                ack[6] = chk;
                total = 7 + int'(rx_len);
                n = 0;
                for (int i = 0; i < 7; i++)
                begin
                    step_out.push_back('{KIND_ACK, rx_func, ack[i], (n + 1) == total});
                    n++;
                end
                for (int i = 0; i < int'(rx_len); i++)
                begin
                    step_out.push_back('{KIND_PAY, rx_func, pay_mem[i], (n + 1) == total});
                    n++;
                end
                acked_frames++;
            end
            rx_pos = POS_HUNT;
        end
    endfunction

    // offer one byte, wait for it to be taken, record what it should cause
    task automatic send_byte(input logic [7:0] b, input row_check_t chk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (rx_pos != POS_HUNT || b == tfr_pkg::HDR0)
            live_items++;
        items_sent++;
        deframe_byte(b);
        case (chk)
            BY_MODEL:
                foreach (step_out[i])
                    pending_out.push_back(step_out[i]);
            ZERO_LEN_ACK:
                for (int i = 0; i < 7; i++)
                    pending_out.push_back('{KIND_ACK, 8'h00,
                                            ZERO_LEN_ACK_BYTES[55 - 8 * i -: 8], i == 6});
            default:
                ;
        endcase
    endtask

    function automatic logic [7:0] pick_payload();
        logic [7:0] v;
        case ($urandom_range(0, 11))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = tfr_pkg::HDR0;
            3:       v = tfr_pkg::HDR1;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // one random frame: mostly well formed, some broken, some line noise
    task automatic send_random_frame();
        logic [7:0] fb [$];
        logic [7:0] sum;
        logic [7:0] x;
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            case ($urandom_range(0, 9))
                7:       len = MAX_PAYLOAD;
                8:       len = $urandom_range(7, MAX_PAYLOAD - 1);
                9:       len = 0;
                default: len = $urandom_range(0, 6);
            endcase
            fb.push_back(tfr_pkg::HDR0);
            fb.push_back(tfr_pkg::HDR1);
            fb.push_back(pick_payload());
            fb.push_back(len[7:0]);
            for (int i = 0; i < len; i++)
                fb.push_back(pick_payload());
            sum = 8'h00;
            foreach (fb[i])
                sum += fb[i];
            // corrupt the checksum now and then
            if ($urandom_range(0, 9) == 0)
                sum += 8'($urandom_range(1, 255));
            fb.push_back(sum);
        end
        else if (sel < 80)
        begin
            fb.push_back(tfr_pkg::HDR0);
            if ($urandom_range(0, 1) == 0)
                x = tfr_pkg::HDR0;
            else
            begin
                do
                    x = 8'($urandom_range(0, 255));
                while (x == tfr_pkg::HDR1);
            end
            fb.push_back(x);
        end
        else if (sel < 88)
        begin
            fb.push_back(tfr_pkg::HDR0);
            fb.push_back(tfr_pkg::HDR1);
            fb.push_back(pick_payload());
            fb.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                fb.push_back(8'($urandom_range(0, 255)));
        end
        foreach (fb[i])
            send_byte(fb[i], BY_MODEL);
    endtask

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %02h got %02h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // compare each output item with the oldest expected one
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t: expected no item, got kind %0d func %02h data %02h last %0d",
                         $time, kind, func_code, data_byte, last);
                mismatches++;
            end
            else
            begin
                want = pending_out.pop_front();
                checked_items++;
                if (want.kind == KIND_PAY)
                    payload_items++;
                check_field("kind", {7'd0, want.kind}, {7'd0, kind});
                check_field("func_code", want.func, func_code);
                check_field("data_byte", want.data, data_byte);
                check_field("last", {7'd0, want.last}, {7'd0, last});
            end
        end
    end

    // output stall in random bursts, none once the run has calmed down
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // give up when no item moves for too long
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        // header and length edge cases, each frame starting on a new line
        dir_rows = '{
            '{8'hAA, NO_OUT}, '{8'hAF, NO_OUT}, '{8'h00, NO_OUT}, '{8'h00, NO_OUT},
            '{8'h59, ZERO_LEN_ACK},
            '{8'hAA, NO_OUT}, '{8'hAA, NO_OUT}, '{8'hAF, NO_OUT}, '{8'h00, NO_OUT},
            '{8'hAA, NO_OUT}, '{8'hAF, NO_OUT}, '{8'h12, NO_OUT}, '{8'h21, NO_OUT},
            '{8'hAA, BY_MODEL}, '{8'hAF, BY_MODEL}, '{8'hFF, BY_MODEL}, '{8'h02, BY_MODEL},
            '{8'h00, BY_MODEL}, '{8'hFF, BY_MODEL}, '{8'h59, BY_MODEL},
            '{8'hAA, NO_OUT}, '{8'hAF, NO_OUT}, '{8'h01, NO_OUT}, '{8'h00, NO_OUT},
            '{8'h00, NO_OUT}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_rows[i].b, dir_rows[i].chk);

        // random frames, quiet handshakes towards the end
        while (live_items < RANDOM_ITEMS)
        begin
            calm = (live_items >= CALM_ITEMS);
            send_random_frame();
        end
        in_valid <= 1'b0;

        // drain, then give the block time to show anything extra
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, %0d of them inside frames; %0d frames acknowledged",
                 items_sent, live_items, acked_frames);
        $display("Checked %0d output items, %0d of them payload",
                 checked_items, payload_items);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- telemetry_frame_receiver_with_ack.f -----
rtl/tfr_pkg.sv
rtl/tfr_ram.sv
rtl/tfr_queue.sv
rtl/tfr_front.sv
rtl/tfr_back.sv
rtl/telemetry_frame_receiver_with_ack.sv
dv/tb_telemetry_frame_receiver_with_ack.sv
